// ===== rtl/core/scc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and the arctangent table of the coordinate converter.
// ----------------------------------------------------------------------------
package scc_pkg;

  // number of cordic micro-rotations, 8 to 24
  localparam int CORDIC_STAGES = 16;
  // stages of step logic in the back end pipeline
  localparam int PIPE_DEPTH    = CORDIC_STAGES + 25;

  localparam logic [14:0]        LIMIT_RST = 15'd2560;
  localparam logic signed [35:0] GAIN_Q30  = 36'sd652032874;
  localparam logic signed [29:0] DEG90     = 30'sd36864000;

  typedef enum logic {
    CMD_CART_TO_SPH = 1'b0,
    CMD_SPH_TO_CART = 1'b1
  } cmd_e;

  // one classified item as it waits between front and back
  typedef struct packed {
    cmd_e               cmd;
    logic [31:0]        rad_sq;   // x^2 + y^2 + z^2
    logic [31:0]        hor_sq;   // x^2 + y^2
    logic signed [31:0] z_sc;     // z * 2^16
    logic               org;      // x = y = z = 0
    logic               az_zero;  // x = y = 0
    logic signed [25:0] az_x;
    logic signed [25:0] az_y;
    logic signed [29:0] az_acc;
    logic [15:0]        radius;
    logic signed [29:0] rot_az;
    logic               neg_az;
    logic signed [29:0] rot_el;
    logic               neg_el;
    logic [14:0]        limit;    // never zero
  } entry_t;

  // atan(2^-i) in 1/4096 hundredth degree
  function automatic logic signed [29:0] atan_lut(input int i);
    logic signed [29:0] v;
    case (i)
      0:       v = 30'sd18432000;
      1:       v = 30'sd10881045;
      2:       v = 30'sd5749245;
      3:       v = 30'sd2918407;
      4:       v = 30'sd1464867;
      5:       v = 30'sd733147;
      6:       v = 30'sd366663;
      7:       v = 30'sd183343;
      8:       v = 30'sd91673;
      9:       v = 30'sd45837;
      10:      v = 30'sd22918;
      11:      v = 30'sd11459;
      12:      v = 30'sd5730;
      13:      v = 30'sd2865;
      14:      v = 30'sd1432;
      15:      v = 30'sd716;
      16:      v = 30'sd358;
      17:      v = 30'sd179;
      18:      v = 30'sd90;
      19:      v = 30'sd45;
      20:      v = 30'sd22;
      21:      v = 30'sd11;
      22:      v = 30'sd6;
      23:      v = 30'sd3;
      default: v = 30'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/scc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_in_if
// Request channel of the coordinate converter: valid, ready and one item.
// ----------------------------------------------------------------------------
interface scc_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [15:0]        radius_in;
  logic signed [15:0] azimuth_in;
  logic signed [14:0] elevation_in;

  modport source (output valid, command, pos_x, pos_y, pos_z, radius_in,
                  azimuth_in, elevation_in, input ready);
  modport sink   (input valid, command, pos_x, pos_y, pos_z, radius_in,
                  azimuth_in, elevation_in, output ready);
endinterface

// ===== rtl/core/scc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_out_if
// Result channel of the coordinate converter: valid, ready and one result.
// ----------------------------------------------------------------------------
interface scc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        radius_out;
  logic signed [15:0] azimuth_out;
  logic signed [14:0] elevation_out;
  logic [15:0]        norm_x;
  logic [15:0]        norm_y;
  logic [15:0]        norm_z;

  modport source (output valid, radius_out, azimuth_out, elevation_out,
                  norm_x, norm_y, norm_z, input ready);
  modport sink   (input valid, radius_out, azimuth_out, elevation_out,
                  norm_x, norm_y, norm_z, output ready);
endinterface

// ===== rtl/core/scc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_front
// Accepts beats, holds the clamp limit and prepares operands for the back end.
// ----------------------------------------------------------------------------
module scc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [14:0]     cfg_wdata_i,
  scc_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output scc_pkg::entry_t entry_o
);

  logic [14:0]        limit_q, limit_d;
  logic signed [31:0] xx, yy, zz;
  logic [31:0]        hor_sq;
  logic signed [25:0] xs, ys;
  logic [30:0]        fold_az, fold_el;

  // wrap into +-180 deg, fold beyond +-90 deg, scale to 1/4096 units
  function automatic logic [30:0] fold(input logic signed [17:0] a);
    logic signed [17:0] w;
    logic               n;
    w = a;
    n = 1'b0;
    if (w > 18'sd18000) w = w - 18'sd36000;
    if (w < -18'sd18000) w = w + 18'sd36000;
    if (w > 18'sd9000) begin
      w = w - 18'sd18000;
      n = 1'b1;
    end else if (w < -18'sd9000) begin
      w = w + 18'sd18000;
      n = 1'b1;
    end
    return {n, {{12{w[17]}}, w} <<< 12};
  endfunction

  // clamp limit register, zero acts as one
  always_comb begin
    limit_d = limit_q;
    if (cfg_we_i) limit_d = cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= scc_pkg::LIMIT_RST;
    end else begin
      limit_q <= limit_d;
    end
  end

  // handshake
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // squares
  assign xx     = in_i.pos_x * in_i.pos_x;
  assign yy     = in_i.pos_y * in_i.pos_y;
  assign zz     = in_i.pos_z * in_i.pos_z;
  assign hor_sq = $unsigned(xx) + $unsigned(yy);

  assign xs = {{2{in_i.pos_x[15]}}, in_i.pos_x, 8'b0};
  assign ys = {{2{in_i.pos_y[15]}}, in_i.pos_y, 8'b0};

  assign fold_az = fold({{2{in_i.azimuth_in[15]}}, in_i.azimuth_in});
  assign fold_el = fold({{3{in_i.elevation_in[14]}}, in_i.elevation_in});

  // operand preparation
  always_comb begin
    entry_o         = '0;
    entry_o.cmd     = scc_pkg::cmd_e'(in_i.command);
    entry_o.hor_sq  = hor_sq;
    entry_o.rad_sq  = hor_sq + $unsigned(zz);
    entry_o.z_sc    = {in_i.pos_z, 16'b0};
    entry_o.az_zero = (in_i.pos_x == 16'sd0) && (in_i.pos_y == 16'sd0);
    entry_o.org     = entry_o.az_zero && (in_i.pos_z == 16'sd0);
    // quadrant pre-rotation for the azimuth vectoring
    entry_o.az_x    = xs;
    entry_o.az_y    = ys;
    entry_o.az_acc  = 30'sd0;
    if (xs < 26'sd0) begin
      if (ys >= 26'sd0) begin
        entry_o.az_x   = ys;
        entry_o.az_y   = -xs;
        entry_o.az_acc = scc_pkg::DEG90;
      end else begin
        entry_o.az_x   = -ys;
        entry_o.az_y   = xs;
        entry_o.az_acc = -scc_pkg::DEG90;
      end
    end
    entry_o.radius = in_i.radius_in;
    entry_o.neg_az = fold_az[30];
    entry_o.rot_az = fold_az[29:0];
    entry_o.neg_el = fold_el[30];
    entry_o.rot_el = fold_el[29:0];
    entry_o.limit  = (limit_q == 15'd0) ? 15'd1 : limit_q;
  end

endmodule

// ===== rtl/core/scc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module scc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scc_pkg::entry_t data_i,
  input  logic            pop_i,
  output scc_pkg::entry_t data_o,
  output logic            full_o,
  output logic            empty_o
);

  scc_pkg::entry_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== rtl/core/scc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_back
// Pipelined square roots, cordic units, products and dividers, one step a stage.
// ----------------------------------------------------------------------------
module scc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scc_pkg::entry_t data_i,
  input  logic            empty_i,
  output logic            pop_o,
  scc_out_if.source       out_o
);

  localparam int S  = scc_pkg::CORDIC_STAGES;
  localparam int ND = scc_pkg::PIPE_DEPTH;

  typedef struct packed {
    scc_pkg::cmd_e      cmd;
    logic               org;
    logic               az_zero;
    logic [31:0]        rn;
    logic [15:0]        rr;
    logic [16:0]        rm;
    logic [47:0]        hn;
    logic [23:0]        hr;
    logic [25:0]        hm;
    logic signed [31:0] zs;
    logic signed [35:0] ex;
    logic signed [35:0] ey;
    logic signed [29:0] ea;
    logic signed [35:0] ax;
    logic signed [35:0] ay;
    logic signed [29:0] aa;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [29:0] cz;
    logic               cneg;
    logic signed [35:0] sx;
    logic signed [35:0] sy;
    logic signed [29:0] sz;
    logic               sneg;
    logic [15:0]        radius;
    logic signed [26:0] ca;
    logic signed [26:0] sa;
    logic signed [26:0] ce;
    logic signed [26:0] se;
    logic signed [27:0] rc;
    logic signed [27:0] vx;
    logic signed [27:0] vy;
    logic signed [27:0] vz;
    logic [14:0]        limit;
    logic [2:0][23:0]   drm;
    logic [2:0][16:0]   dn;
    logic [2:0][16:0]   dq;
    logic [15:0]        rad_res;
    logic signed [15:0] az_res;
    logic signed [14:0] el_res;
    logic [15:0]        nx;
    logic [15:0]        ny;
    logic [15:0]        nz;
  } pipe_t;

  pipe_t       stage_q [ND+1];
  pipe_t       nxt [ND];
  logic [ND:0] vld_q;
  logic        en;

  // unpack a queue entry into the first stage
  function automatic pipe_t load_fn(input scc_pkg::entry_t e);
    pipe_t t;
    t         = '0;
    t.cmd     = e.cmd;
    t.org     = e.org;
    t.az_zero = e.az_zero;
    t.rn      = e.rad_sq;
    t.hn      = {e.hor_sq, 16'b0};
    t.zs      = e.z_sc;
    t.ax      = {{10{e.az_x[25]}}, e.az_x};
    t.ay      = {{10{e.az_y[25]}}, e.az_y};
    t.aa      = e.az_acc;
    t.cx      = scc_pkg::GAIN_Q30;
    t.cz      = e.rot_az;
    t.cneg    = e.neg_az;
    t.sx      = scc_pkg::GAIN_Q30;
    t.sz      = e.rot_el;
    t.sneg    = e.neg_el;
    t.radius  = e.radius;
    t.limit   = e.limit;
    return t;
  endfunction

  // work done by stage k
  function automatic pipe_t step_fn(input int k, input pipe_t s);
    pipe_t              t;
    logic [18:0]        r19;
    logic [17:0]        tr18;
    logic [27:0]        h28;
    logic [25:0]        tr26;
    logic signed [35:0] dx, dy;
    logic signed [29:0] tab, acc;
    logic signed [35:0] rx;
    logic signed [43:0] p44a, p44b;
    logic signed [54:0] p55a, p55b;
    logic signed [27:0] lim28, vc;
    logic signed [27:0] vv [3];
    logic [23:0]        tt;
    logic [39:0]        num;
    logic [23:0]        dv;
    logic [24:0]        r25;
    t = s;

    // radius square root, two bits a stage
    if (k < 16) begin
      r19  = {t.rm, t.rn[31:30]};
      tr18 = {t.rr, 2'b01};
      if (r19 >= {1'b0, tr18}) begin
        t.rm = 17'(r19 - {1'b0, tr18});
        t.rr = {t.rr[14:0], 1'b1};
      end else begin
        t.rm = r19[16:0];
        t.rr = {t.rr[14:0], 1'b0};
      end
      t.rn = {t.rn[29:0], 2'b00};
    end
    if (k == 16) begin
      t.rad_res = ({1'b0, t.rr} < t.rm) ? t.rr + 16'd1 : t.rr;
    end

    // horizontal length square root
    if (k < 24) begin
      h28  = {t.hm, t.hn[47:46]};
      tr26 = {t.hr, 2'b01};
      if (h28 >= {2'b00, tr26}) begin
        t.hm = 26'(h28 - {2'b00, tr26});
        t.hr = {t.hr[22:0], 1'b1};
      end else begin
        t.hm = h28[25:0];
        t.hr = {t.hr[22:0], 1'b0};
      end
      t.hn = {t.hn[45:0], 2'b00};
    end
    if (k == 23) begin
      t.ex = {12'b0, t.hr};
      t.ey = {{4{t.zs[31]}}, t.zs};
      t.ea = 30'sd0;
    end

    // elevation vectoring
    if (k >= 24 && k < 24 + S) begin
      dx  = t.ey >>> (k - 24);
      dy  = t.ex >>> (k - 24);
      tab = scc_pkg::atan_lut(k - 24);
      if (!t.ey[35]) begin
        t.ex = t.ex + dx;
        t.ey = t.ey - dy;
        t.ea = t.ea + tab;
      end else begin
        t.ex = t.ex - dx;
        t.ey = t.ey + dy;
        t.ea = t.ea - tab;
      end
    end
    if (k == 24 + S) begin
      acc = (t.ea + 30'sd2048) >>> 12;
      if (acc > 30'sd9000) acc = 30'sd9000;
      if (acc < -30'sd9000) acc = -30'sd9000;
      t.el_res = t.org ? 15'sd0 : 15'(acc);
    end

    // azimuth vectoring and both sine/cosine rotations
    if (k < S) begin
      tab = scc_pkg::atan_lut(k);
      dx  = t.ay >>> k;
      dy  = t.ax >>> k;
      if (!t.ay[35]) begin
        t.ax = t.ax + dx;
        t.ay = t.ay - dy;
        t.aa = t.aa + tab;
      end else begin
        t.ax = t.ax - dx;
        t.ay = t.ay + dy;
        t.aa = t.aa - tab;
      end
      dx = t.cy >>> k;
      dy = t.cx >>> k;
      if (!t.cz[29]) begin
        t.cx = t.cx - dx;
        t.cy = t.cy + dy;
        t.cz = t.cz - tab;
      end else begin
        t.cx = t.cx + dx;
        t.cy = t.cy - dy;
        t.cz = t.cz + tab;
      end
      dx = t.sy >>> k;
      dy = t.sx >>> k;
      if (!t.sz[29]) begin
        t.sx = t.sx - dx;
        t.sy = t.sy + dy;
        t.sz = t.sz - tab;
      end else begin
        t.sx = t.sx + dx;
        t.sy = t.sy - dy;
        t.sz = t.sz + tab;
      end
    end

    // angle rounding, q1.24 sine and cosine
    if (k == S) begin
      acc = (t.aa + 30'sd2048) >>> 12;
      if (acc > 30'sd18000) acc = 30'sd18000;
      if (acc < -30'sd18000) acc = -30'sd18000;
      t.az_res = t.az_zero ? 16'sd0 : 16'(acc);
      rx   = (t.cx + 36'sd32) >>> 6;
      t.ca = t.cneg ? -27'(rx) : 27'(rx);
      rx   = (t.cy + 36'sd32) >>> 6;
      t.sa = t.cneg ? -27'(rx) : 27'(rx);
      rx   = (t.sx + 36'sd32) >>> 6;
      t.ce = t.sneg ? -27'(rx) : 27'(rx);
      rx   = (t.sy + 36'sd32) >>> 6;
      t.se = t.sneg ? -27'(rx) : 27'(rx);
    end

    // r * cos(el) and r * sin(el)
    if (k == S + 1) begin
      p44a = $signed({1'b0, t.radius}) * t.ce;
      p44b = $signed({1'b0, t.radius}) * t.se;
      t.rc = 28'((p44a + 44'sd32768) >>> 16);
      t.vz = 28'((p44b + 44'sd32768) >>> 16);
    end

    // horizontal projection onto x and y
    if (k == S + 2) begin
      p55a = t.rc * t.ca;
      p55b = t.rc * t.sa;
      t.vx = 28'((p55a + 55'sd8388608) >>> 24);
      t.vy = 28'((p55b + 55'sd8388608) >>> 24);
    end

    // clamp and form the dividends
    if (k == S + 3) begin
      lim28 = $signed({5'b0, t.limit, 8'b0});
      vv[0] = t.vx;
      vv[1] = t.vy;
      vv[2] = t.vz;
      for (int c = 0; c < 3; c++) begin
        vc = vv[c];
        if (vc > lim28) vc = lim28;
        if (vc < -lim28) vc = -lim28;
        tt       = 24'(vc + lim28);
        num      = {tt, 16'b0} + {17'b0, t.limit, 8'b0};
        t.drm[c] = {1'b0, num[39:17]};
        t.dn[c]  = num[16:0];
        t.dq[c]  = 17'd0;
      end
    end

    // restoring division by twice the limit, one quotient bit a stage
    if (k >= S + 4 && k <= S + 20) begin
      dv = {t.limit, 9'b0};
      for (int c = 0; c < 3; c++) begin
        r25 = {t.drm[c], t.dn[c][16]};
        if (r25 >= {1'b0, dv}) begin
          t.drm[c] = 24'(r25 - {1'b0, dv});
          t.dq[c]  = {t.dq[c][15:0], 1'b1};
        end else begin
          t.drm[c] = r25[23:0];
          t.dq[c]  = {t.dq[c][15:0], 1'b0};
        end
        t.dn[c] = {t.dn[c][15:0], 1'b0};
      end
    end
    if (k == S + 21) begin
      t.nx = t.dq[0][16] ? 16'hFFFF : t.dq[0][15:0];
      t.ny = t.dq[1][16] ? 16'hFFFF : t.dq[1][15:0];
      t.nz = t.dq[2][16] ? 16'hFFFF : t.dq[2][15:0];
    end
    return t;
  endfunction

  // stage logic
  for (genvar g = 0; g < ND; g++) begin : g_stage
    assign nxt[g] = step_fn(g, stage_q[g]);
  end

  // the pipeline moves unless the result register is held
  assign en    = !vld_q[ND] || out_o.ready;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ND-1:0], !empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stage_q[0] <= load_fn(data_i);
      for (int i = 0; i < ND; i++) stage_q[i+1] <= nxt[i];
    end
  end

  // result beat, unused fields zero
  always_comb begin
    out_o.valid         = vld_q[ND];
    out_o.radius_out    = '0;
    out_o.azimuth_out   = '0;
    out_o.elevation_out = '0;
    out_o.norm_x        = '0;
    out_o.norm_y        = '0;
    out_o.norm_z        = '0;
    if (stage_q[ND].cmd == scc_pkg::CMD_CART_TO_SPH) begin
      out_o.radius_out    = stage_q[ND].rad_res;
      out_o.azimuth_out   = stage_q[ND].az_res;
      out_o.elevation_out = stage_q[ND].el_res;
    end else begin
      out_o.norm_x = stage_q[ND].nx;
      out_o.norm_y = stage_q[ND].ny;
      out_o.norm_z = stage_q[ND].nz;
    end
  end

endmodule

// ===== rtl/core/spherical_cartesian_converter_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is ready; every square root bit,
// cordic rotation and quotient bit has its own pipeline stage, and a two-entry queue
// decouples input from output.
// Reset clears the queue and all stage valids and sets the clamp limit to 2560.
// ----------------------------------------------------------------------------
// spherical_cartesian_converter_unit
// Cartesian to spherical and spherical to normalized cartesian conversion.
// ----------------------------------------------------------------------------
module spherical_cartesian_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  scc_in_if.sink      in_i,
  scc_out_if.source   out_o
);

  scc_pkg::entry_t q_wdata, q_rdata;
  logic            q_push, q_pop, q_full, q_empty;

  // front: accept and classify
  scc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .entry_o     (q_wdata)
  );

  // queue between front and back
  scc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: arithmetic pipeline
  scc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (q_rdata),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  // checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_empty) else $error("queue full and empty at once");

endmodule

// ===== verif/tb_spherical_cartesian_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spherical_cartesian_converter_unit
// Self-checking bench: directed and random conversions in both directions,
// several clamp limits, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_spherical_cartesian_converter_unit;
  import scc_pkg::*;

  localparam int      LATENCY   = CORDIC_STAGES + 26;
  localparam longint  QUART_ANG = 64'sd36864000;
  localparam longint  ROT_GAIN  = 64'sd652032874;
  localparam longint  ARCTAN_Q12 [24] = '{
    18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
    91673, 45837, 22918, 11459, 5730, 2865, 1432, 716,
    358, 179, 90, 45, 22, 11, 6, 3};

  typedef struct {
    logic [15:0]        radius;
    logic signed [15:0] azimuth;
    logic signed [14:0] elevation;
    logic [15:0]        nx;
    logic [15:0]        ny;
    logic [15:0]        nz;
  } conv_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;

  scc_in_if  in_if ();
  scc_out_if out_if ();

  spherical_cartesian_converter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #2 clk_i = ~clk_i;

  conv_res_t   pending_res [$];
  logic [14:0] clamp_limit = LIMIT_RST;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_cycles = 0;
  int          err_count = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          cfg_writes = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n,
                                               output longint unsigned rem);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    rem = n;
    return res;
  endfunction

  function automatic longint atan2_hdeg(longint x, longint y);
    longint acc, t, dx, dy;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = QUART_ANG;
      end else begin
        t = x; x = -y; y = t; acc = -QUART_ANG;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += ARCTAN_Q12[i];
      end else begin
        x -= dx; y += dy; acc -= ARCTAN_Q12[i];
      end
    end
    return clampl(round_shr(acc, 12), -18000, 18000);
  endfunction

  task automatic cos_sin_q24(input longint a, output longint c, output longint s);
    logic   flip;
    longint x, y, z, dx, dy;
    flip = 1'b0;
    x = ROT_GAIN;
    y = 0;
    if (a > 18000) a -= 36000;
    if (a < -18000) a += 36000;
    if (a > 9000) begin
      a -= 18000; flip = 1'b1;
    end else if (a < -9000) begin
      a += 18000; flip = 1'b1;
    end
    z = a * 4096;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN_Q12[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN_Q12[i];
      end
    end
    x = round_shr(x, 6);
    y = round_shr(y, 6);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [15:0] norm_q16(longint v, longint lim);
    longint n;
    v = clampl(v, -lim, lim);
    n = ((v + lim) * 65536 + lim) / (2 * lim);
    return 16'(clampl(n, 0, 65535));
  endfunction

  task automatic convert_item(input cmd_e cmd, input logic signed [15:0] px,
                              input logic signed [15:0] py, input logic signed [15:0] pz,
                              input logic [15:0] rin, input logic signed [15:0] azin,
                              input logic signed [14:0] elin, output conv_res_t res);
    longint x, y, z, az, el, r, ca, sa, ce, se, rc, lim, h;
    longint unsigned sq, rem, rt;
    res = '{default: '0};
    if (cmd == CMD_CART_TO_SPH) begin
      x  = px; y = py; z = pz;
      sq = longint'(x * x + y * y + z * z);
      rt = int_sqrt(sq, rem);
      if (rem > rt) rt++;
      if (rt > 65535) rt = 65535;
      az = atan2_hdeg(x * 256, y * 256);
      el = 0;
      if (x != 0 || y != 0 || z != 0) begin
        h  = longint'(int_sqrt(longint'(x * x + y * y) << 16, rem));
        el = clampl(atan2_hdeg(h, z * 65536), -9000, 9000);
      end
      res.radius    = 16'(rt);
      res.azimuth   = 16'(az);
      res.elevation = 15'(el);
    end else begin
      r = rin;
      cos_sin_q24(longint'(azin), ca, sa);
      cos_sin_q24(longint'(elin), ce, se);
      rc  = round_shr(r * ce, 16);
      lim = longint'(clamp_limit == 0 ? 15'd1 : clamp_limit) * 256;
      res.nx = norm_q16(round_shr(rc * ca, 24), lim);
      res.ny = norm_q16(round_shr(rc * sa, 24), lim);
      res.nz = norm_q16(round_shr(r * se, 16), lim);
    end
  endtask

  // ---------------------------------------------------------------- helpers
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  // drive one beat at the falling edge, hold until accepted
  task automatic send_item(input cmd_e cmd, input logic signed [15:0] px,
                           input logic signed [15:0] py, input logic signed [15:0] pz,
                           input logic [15:0] rin, input logic signed [15:0] azin,
                           input logic signed [14:0] elin);
    conv_res_t res;
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.pos_x        <= px;
    in_if.pos_y        <= py;
    in_if.pos_z        <= pz;
    in_if.radius_in    <= rin;
    in_if.azimuth_in   <= azin;
    in_if.elevation_in <= elin;
    do @(posedge clk_i); while (!in_if.ready);
    convert_item(cmd, px, py, pz, rin, azin, elin, res);
    pending_res.push_back(res);
    beats_in++;
    @(negedge clk_i);
  endtask

  task automatic send_cart(input int px, input int py, input int pz);
    send_item(CMD_CART_TO_SPH, 16'(px), 16'(py), 16'(pz),
              16'($urandom), 16'($urandom), 15'($urandom));
  endtask

  task automatic send_sph(input int rin, input int azin, input int elin);
    send_item(CMD_SPH_TO_CART, 16'($urandom), 16'($urandom), 16'($urandom),
              16'(rin), 16'(azin), 15'(elin));
  endtask

  task automatic drain_pipe();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (pending_res.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  // limit writes only with the pipeline empty
  task automatic write_limit(input logic [14:0] val);
    drain_pipe();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    clamp_limit = val;
    cfg_writes++;
  endtask

  task automatic send_random();
    int sel;
    sel = $urandom_range(9);
    if ($urandom_range(1)) begin
      case (sel)
        0:       send_cart(0, 0, $urandom);
        1:       send_cart($urandom_range(255) - 128, $urandom_range(255) - 128,
                           $urandom_range(255) - 128);
        2:       send_cart(-$urandom_range(32768), 0, $urandom);
        3:       send_cart($urandom, $urandom_range(1) ? 0 : $urandom, 0);
        default: send_cart($urandom, $urandom, $urandom);
      endcase
    end else begin
      case (sel)
        0:       send_sph($urandom, 18000 * ($urandom_range(2) - 1),
                          9000 * ($urandom_range(2) - 1));
        1:       send_sph($urandom_range(4095), $urandom_range(36000) - 18000,
                          $urandom_range(18000) - 9000);
        default: send_sph($urandom, $urandom_range(36000) - 18000,
                          $urandom_range(18000) - 9000);
      endcase
    end
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready  <= ($urandom_range(99) >= recv_idle);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    conv_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      beats_out++;
      if (pending_res.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = pending_res.pop_front();
        if (out_if.radius_out !== e.radius)
          report_mismatch($sformatf("radius %0d exp %0d", out_if.radius_out, e.radius));
        if (out_if.azimuth_out !== e.azimuth)
          report_mismatch($sformatf("azimuth %0d exp %0d", out_if.azimuth_out, e.azimuth));
        if (out_if.elevation_out !== e.elevation)
          report_mismatch($sformatf("elevation %0d exp %0d", out_if.elevation_out,
                                    e.elevation));
        if (out_if.norm_x !== e.nx)
          report_mismatch($sformatf("norm_x %0d exp %0d", out_if.norm_x, e.nx));
        if (out_if.norm_y !== e.ny)
          report_mismatch($sformatf("norm_y %0d exp %0d", out_if.norm_y, e.ny));
        if (out_if.norm_z !== e.nz)
          report_mismatch($sformatf("norm_z %0d exp %0d", out_if.norm_z, e.nz));
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_cart(0, 0, 0);                  // origin
    send_cart(0, 0, 32767);              // vertical axis up
    send_cart(0, 0, -32768);             // vertical axis down
    send_cart(-256, 0, 0);               // negative x axis
    send_cart(-32768, 0, 100);
    send_cart(32767, 32767, 32767);      // largest positive corner
    send_cart(-32768, -32768, -32768);
    send_cart(0, 256, 0);
    send_cart(0, -256, 0);
    send_cart(1, 1, 1);
    send_cart(-1, -1, -1);
    send_sph(0, 0, 0);
    send_sph(65535, 0, 0);
    send_sph(65535, 18000, 0);
    send_sph(65535, -18000, 0);
    send_sph(65535, 9000, 9000);
    send_sph(65535, -9000, -9000);
    send_sph(2560, 4500, 4500);
    send_sph(1280, 13500, -4500);
    send_sph(65535, -13500, 8999);
    send_sph(1, 1, -1);
  endtask

  task automatic test_limits();
    write_limit(15'd0);                  // zero acts as one
    repeat (8) send_random();
    write_limit(15'd1);
    repeat (8) send_random();
    write_limit(15'd32767);
    repeat (8) send_sph(65535, $urandom_range(36000) - 18000, $urandom_range(18000) - 9000);
    write_limit(15'd16384);
    repeat (8) send_random();
  endtask

  task automatic test_random(input int n);
    write_limit(15'($urandom_range(32767, 1)));
    repeat (n) send_random();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (60) send_random();
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    int guard;
    in_if.valid        = 1'b0;
    in_if.command      = CMD_CART_TO_SPH;
    in_if.pos_x        = '0;
    in_if.pos_y        = '0;
    in_if.pos_z        = '0;
    in_if.radius_in    = '0;
    in_if.azimuth_in   = '0;
    in_if.elevation_in = '0;
    out_if.ready       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    send_idle = 32; recv_idle = 69;
    test_random(200);
    test_limits();
    test_random(200);
    send_idle = 69; recv_idle = 32;
    test_random(200);
    test_random(200);
    send_idle = 0; recv_idle = 0;
    test_backpressure();
    test_random(200);
    write_limit(LIMIT_RST);
    test_random(200);

    in_if.valid <= 1'b0;
    guard = 0;
    while (pending_res.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending_res.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_res.size()));
    repeat (LATENCY + 16) @(negedge clk_i);

    $display("run covered %0d conversions in, %0d results out, %0d limit writes",
             beats_in, beats_out, cfg_writes);
    $display("both commands, axis and origin cases, limit extremes, idling and a long stall");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== spherical_cartesian_converter_unit.f =====
rtl/core/scc_pkg.sv
rtl/core/scc_in_if.sv
rtl/core/scc_out_if.sv
rtl/core/scc_front.sv
rtl/core/scc_queue.sv
rtl/core/scc_back.sv
rtl/core/spherical_cartesian_converter_unit.sv
verif/tb_spherical_cartesian_converter_unit.sv
